// ===== src/dtsi_pkg.sv =====
// Shared character codes and port field widths for the decimal text parser.
package dtsi_pkg;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int IN_TDATA_W  = 8;
    localparam int UNITS_W     = 64;
    localparam int SCALE_W     = 8;
    localparam int OUT_TDATA_W = UNITS_W + SCALE_W;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== src/dtsi_div10.sv =====
// Divide-by-ten unit that walks the dividend sixteen bits per cycle by reciprocal multiplication.
module dtsi_div10 #(
    parameter int WIDTH = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WIDTH-1:0]     i_dividend,
    output dtsi_pkg::t_div_status o_status,
    output logic [WIDTH-1:0]     o_quotient
);
    import dtsi_pkg::*;

    localparam int CHUNK_W = 16;
    localparam int N_CHUNK = (WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W   = N_CHUNK * CHUNK_W;
    localparam int CNT_W   = $clog2(N_CHUNK);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_CHUNK - 1);
    localparam logic [39:0]      RECIP    = 40'd838861;

    logic [PAD_W-1:0] r_q;
    logic [3:0]       r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [19:0] n_t;
    logic [39:0] n_prod;
    logic [15:0] n_qchunk;
    logic [19:0] n_back;
    logic [19:0] n_left;

    // The partial dividend stays below ten times 2^16, where the scaled reciprocal is exact.
    always_comb begin
        n_t      = {r_rem, r_q[PAD_W-1 -: CHUNK_W]};
        n_prod   = 40'(n_t) * RECIP;
        n_qchunk = n_prod[38:23];
        n_back   = ({4'd0, n_qchunk} << 3) + ({4'd0, n_qchunk} << 1);
        n_left   = n_t - n_back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_q    <= PAD_W'(i_dividend);
                r_rem  <= 4'd0;
                r_cnt  <= CNT_LAST;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[PAD_W-CHUNK_W-1:0], n_qchunk};
                r_rem <= n_left[3:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_q[WIDTH-1:0];

endmodule

// ===== src/decimal_text_to_scaled_integer.sv =====
// Top level: parses decimal text one character per transfer into a scaled 64-bit integer.
// A character that does not end the string leaves the block ready for the next character.
// The final character sends the parser to a fit check; while the value is outside the signed
// 64-bit range and the scale is above zero, the divider divides it by ten and the scale drops by one.
// A result waits in an output register; a finished parse holds its result, and the input, while that register is full.
// Reset is synchronous and active low; it clears the parse state and the output valid.
module decimal_text_to_scaled_integer #(
    parameter int ACC_WIDTH = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [dtsi_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // char_code
    input  logic                               i_s_tuser,  // has_char
    input  logic                               i_s_tlast,  // last
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [dtsi_pkg::OUT_TDATA_W-1:0]   o_m_tdata,  // units[63:0], scale[71:64]
    output logic                               o_m_tuser   // overflow
);
    import dtsi_pkg::*;

    localparam int EXT_W = ACC_WIDTH + 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIT,
        S_DIV
    } t_state;

    t_state                 r_state;
    logic [ACC_WIDTH-1:0]   r_acc;
    logic [SCALE_W-1:0]     r_frac;
    logic                   r_neg;
    logic                   r_after_dot;
    logic                   r_stopped;
    logic                   r_first;
    logic                   r_ovf;
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic                   r_m_user;

    logic                   n_accept;
    logic [7:0]             n_digit8;
    logic [EXT_W-1:0]       n_prod;
    logic                   n_is_sign;
    logic                   n_is_digit;
    logic                   n_fits;
    logic [UNITS_W-1:0]     n_low;
    logic [UNITS_W-1:0]     n_units;
    logic                   n_out_free;
    logic                   n_div_start;
    logic                   n_emit;

    t_div_status            w_div_status;
    logic [ACC_WIDTH-1:0]   w_quotient;

    always_comb begin
        n_accept   = i_s_tvalid && o_s_tready;
        n_digit8   = i_s_tdata - CHAR_ZERO;
        n_prod     = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                     + EXT_W'(n_digit8[3:0]);
        n_is_sign  = (i_s_tdata == CHAR_PLUS) || (i_s_tdata == CHAR_MINUS);
        n_is_digit = (i_s_tdata >= CHAR_ZERO) && (i_s_tdata <= CHAR_NINE);
        n_low      = r_acc[UNITS_W-1:0];
        n_fits     = (r_acc[ACC_WIDTH-1:UNITS_W] == '0)
                     && (!n_low[UNITS_W-1] || (r_neg && n_low[UNITS_W-2:0] == '0));
        n_units    = r_neg ? (UNITS_W'(0) - n_low) : n_low;
        n_out_free = !r_m_valid || i_m_tready;
        n_div_start = (r_state == S_FIT) && !n_fits && (r_frac != '0);
        n_emit     = (r_state == S_FIT) && !n_div_start && n_out_free;
    end

    dtsi_div10 #(
        .WIDTH(ACC_WIDTH)
    ) u_div10 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (r_acc),
        .o_status   (w_div_status),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_frac      <= '0;
            r_neg       <= 1'b0;
            r_after_dot <= 1'b0;
            r_stopped   <= 1'b0;
            r_first     <= 1'b1;
            r_ovf       <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (n_emit) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        if (i_s_tuser && !r_stopped) begin
                            priority if (r_first && n_is_sign) begin
                                r_neg <= (i_s_tdata == CHAR_MINUS);
                            end else if (i_s_tdata == CHAR_DOT) begin
                                r_after_dot <= 1'b1;
                            end else if (n_is_digit) begin
                                r_acc <= n_prod[ACC_WIDTH-1:0];
                                if ((n_prod[EXT_W-1:ACC_WIDTH] != '0)
                                    || (r_after_dot && r_frac == '1)) begin
                                    r_ovf <= 1'b1;
                                end
                                if (r_after_dot && r_frac != '1) begin
                                    r_frac <= r_frac + 1'b1;
                                end
                            end else begin
                                r_stopped <= 1'b1;
                            end
                        end
                        if (i_s_tuser) begin
                            r_first <= 1'b0;
                        end
                        if (i_s_tlast) begin
                            r_state <= S_FIT;
                        end
                    end
                end
                S_FIT: begin
                    if (n_div_start) begin
                        r_state <= S_DIV;
                    end else if (n_out_free) begin
                        r_m_data    <= {r_frac, n_units};
                        r_m_user    <= r_ovf || !n_fits;
                        r_acc       <= '0;
                        r_frac      <= '0;
                        r_neg       <= 1'b0;
                        r_after_dot <= 1'b0;
                        r_stopped   <= 1'b0;
                        r_first     <= 1'b1;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (w_div_status.done) begin
                        r_acc   <= w_quotient;
                        r_frac  <= r_frac - 1'b1;
                        r_state <= S_FIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

// ===== src/dtsi_checker.sv =====
// Port-level checker for the decimal text parser, bound to the top level.
module dtsi_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             i_s_tlast,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [dtsi_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                             o_m_tuser
);
    import dtsi_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled result changed");

    a_mid_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tlast) |=> o_s_tready)
        else $error("not ready after a character transfer that is not last");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("ready right after the last character transfer");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared while the parser was idle");

endmodule

bind decimal_text_to_scaled_integer dtsi_checker u_dtsi_checker (.*);
